FILE: rtl/psd_pkg.sv
// Shared types and constants for the point-to-segment distance block.
`timescale 1ns / 1ps
package psd_pkg;

	localparam int COORD_BITS_DEF = 16;
	localparam int FRAC_BITS_DEF  = 8;
	localparam int DIST_W         = 25;
	localparam logic [DIST_W-1:0] DIST_MAX = '1;

	typedef enum logic [1:0] {
		CASE_DEGEN    = 2'd0,
		CASE_START    = 2'd1,
		CASE_END      = 2'd2,
		CASE_INTERIOR = 2'd3
	} case_t;

	// Per-item control that travels beside the datapath.
	typedef struct packed {
		logic  valid;
		case_t code;
	} tag_t;

endpackage

FILE: rtl/psd_query_if.sv
// Query channel: point and segment endpoints.
`timescale 1ns / 1ps
interface psd_query_if #(
	parameter int CW = 16
) ();
	logic valid;
	logic ready;
	logic signed [CW-1:0] point_x;
	logic signed [CW-1:0] point_y;
	logic signed [CW-1:0] seg_start_x;
	logic signed [CW-1:0] seg_start_y;
	logic signed [CW-1:0] seg_end_x;
	logic signed [CW-1:0] seg_end_y;

	modport source (
		output valid, point_x, point_y, seg_start_x, seg_start_y, seg_end_x, seg_end_y,
		input  ready
	);
	modport sink (
		input  valid, point_x, point_y, seg_start_x, seg_start_y, seg_end_x, seg_end_y,
		output ready
	);
endinterface

FILE: rtl/psd_result_if.sv
// Result channel: distance and nearest-point case.
`timescale 1ns / 1ps
interface psd_result_if ();
	logic        valid;
	logic        ready;
	logic [24:0] distance_q8;
	logic [1:0]  nearest_case;

	modport source (
		output valid, distance_q8, nearest_case,
		input  ready
	);
	modport sink (
		input  valid, distance_q8, nearest_case,
		output ready
	);
endinterface

FILE: rtl/psd_front.sv
// Front end: differences, products, case decision and numerator/denominator select.
`timescale 1ns / 1ps
module psd_front
	import psd_pkg::*;
#(
	parameter int CW = COORD_BITS_DEF
) (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   en,
	input  logic                   in_valid,
	input  logic signed [CW-1:0]   px,
	input  logic signed [CW-1:0]   py,
	input  logic signed [CW-1:0]   ax,
	input  logic signed [CW-1:0]   ay,
	input  logic signed [CW-1:0]   bx,
	input  logic signed [CW-1:0]   by,
	output tag_t                   tag,
	output logic [4*CW+1:0]        num,
	output logic [2*CW:0]          den
);
	localparam int DW  = CW + 1;
	localparam int PW  = 2 * DW;
	localparam int SW  = PW + 1;
	localparam int DVW = 2 * CW + 1;
	localparam int CM  = 2 * CW + 2;
	localparam int H   = (CM + 1) / 2;
	localparam int HH  = CM - H;
	localparam int NW  = 4 * CW + 2;

	// stage 1: difference vectors
	logic                 valid_s1;
	logic signed [DW-1:0] v1x_s1, v1y_s1, v2x_s1, v2y_s1, v3x_s1, v3y_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (en) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			v1x_s1 <= DW'(bx) - DW'(ax);
			v1y_s1 <= DW'(by) - DW'(ay);
			v2x_s1 <= DW'(px) - DW'(ax);
			v2y_s1 <= DW'(py) - DW'(ay);
			v3x_s1 <= DW'(px) - DW'(bx);
			v3y_s1 <= DW'(py) - DW'(by);
		end
	end

	// stage 2: all products
	logic                 valid_s2, degen_s2;
	logic signed [PW-1:0] d1a_s2, d1b_s2, d2a_s2, d2b_s2, cra_s2, crb_s2;
	logic signed [PW-1:0] l1_s2, l2_s2, ea1_s2, ea2_s2, eb1_s2, eb2_s2;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (en) begin
			valid_s2 <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			degen_s2 <= (v1x_s1 == '0) && (v1y_s1 == '0);
			d1a_s2   <= PW'(v1x_s1) * PW'(v2x_s1);
			d1b_s2   <= PW'(v1y_s1) * PW'(v2y_s1);
			d2a_s2   <= PW'(v1x_s1) * PW'(v3x_s1);
			d2b_s2   <= PW'(v1y_s1) * PW'(v3y_s1);
			cra_s2   <= PW'(v1x_s1) * PW'(v2y_s1);
			crb_s2   <= PW'(v2x_s1) * PW'(v1y_s1);
			l1_s2    <= PW'(v1x_s1) * PW'(v1x_s1);
			l2_s2    <= PW'(v1y_s1) * PW'(v1y_s1);
			ea1_s2   <= PW'(v2x_s1) * PW'(v2x_s1);
			ea2_s2   <= PW'(v2y_s1) * PW'(v2y_s1);
			eb1_s2   <= PW'(v3x_s1) * PW'(v3x_s1);
			eb2_s2   <= PW'(v3y_s1) * PW'(v3y_s1);
		end
	end

	// stage 3: dot products, cross product, squared lengths
	logic                 valid_s3, degen_s3;
	logic signed [SW-1:0] dot1_s3, dot2_s3, cross_s3;
	logic        [DVW-1:0] len2_s3, da_s3, db_s3;
	logic signed [SW-1:0] len2_sum, da_sum, db_sum;

	assign len2_sum = SW'(l1_s2) + SW'(l2_s2);
	assign da_sum   = SW'(ea1_s2) + SW'(ea2_s2);
	assign db_sum   = SW'(eb1_s2) + SW'(eb2_s2);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s3 <= 1'b0;
		end else if (en) begin
			valid_s3 <= valid_s2;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			degen_s3 <= degen_s2;
			dot1_s3  <= SW'(d1a_s2) + SW'(d1b_s2);
			dot2_s3  <= SW'(d2a_s2) + SW'(d2b_s2);
			cross_s3 <= SW'(cra_s2) - SW'(crb_s2);
			len2_s3  <= len2_sum[DVW-1:0];
			da_s3    <= da_sum[DVW-1:0];
			db_s3    <= db_sum[DVW-1:0];
		end
	end

	// stage 4: case decision, |cross|
	logic           valid_s4;
	case_t          code_s4;
	logic [CM-1:0]  cmag_s4;
	logic [DVW-1:0] len2_s4, d2_s4;
	case_t          code_c;
	logic [SW-1:0]  cabs;

	always_comb begin
		if (degen_s3) begin
			code_c = CASE_DEGEN;
		end else if (dot1_s3 < 0) begin
			code_c = CASE_START;
		end else if (dot2_s3 > 0) begin
			code_c = CASE_END;
		end else begin
			code_c = CASE_INTERIOR;
		end
		cabs = (cross_s3 < 0) ? SW'(-cross_s3) : SW'(cross_s3);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s4 <= 1'b0;
		end else if (en) begin
			valid_s4 <= valid_s3;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			code_s4 <= code_c;
			cmag_s4 <= cabs[CM-1:0];
			len2_s4 <= len2_s3;
			d2_s4   <= (code_c == CASE_END) ? db_s3 : da_s3;
		end
	end

	// stage 5: |cross|^2 as three half-width partial products
	logic              valid_s5;
	case_t             code_s5;
	logic [2*H-1:0]    pll_s5;
	logic [CM-1:0]     plh_s5;
	logic [2*HH-1:0]   phh_s5;
	logic [DVW-1:0]    len2_s5, d2_s5;
	logic [H-1:0]      c_lo;
	logic [HH-1:0]     c_hi;

	assign c_lo = cmag_s4[H-1:0];
	assign c_hi = cmag_s4[CM-1:H];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s5 <= 1'b0;
		end else if (en) begin
			valid_s5 <= valid_s4;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			code_s5 <= code_s4;
			pll_s5  <= (2*H)'(c_lo) * (2*H)'(c_lo);
			plh_s5  <= CM'(c_lo) * CM'(c_hi);
			phh_s5  <= (2*HH)'(c_hi) * (2*HH)'(c_hi);
			len2_s5 <= len2_s4;
			d2_s5   <= d2_s4;
		end
	end

	// stage 6: numerator and denominator for the shared divide/root path
	logic           valid_s6;
	case_t          code_s6;
	logic [NW-1:0]  num_s6;
	logic [DVW-1:0] den_s6;
	logic [NW-1:0]  csq;

	assign csq = (NW'(phh_s5) << (2 * H)) + (NW'(plh_s5) << (H + 1)) + NW'(pll_s5);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s6 <= 1'b0;
		end else if (en) begin
			valid_s6 <= valid_s5;
		end
	end

	// endpoint cases divide by one, so the quotient is just d2 scaled
	always_ff @(posedge clk) begin
		if (en) begin
			code_s6 <= code_s5;
			num_s6  <= (code_s5 == CASE_INTERIOR) ? csq : NW'(d2_s5);
			den_s6  <= (code_s5 == CASE_INTERIOR) ? len2_s5 : DVW'(1);
		end
	end

	assign tag.valid = valid_s6;
	assign tag.code  = code_s6;
	assign num       = num_s6;
	assign den       = den_s6;

endmodule

FILE: rtl/psd_div.sv
// Pipelined restoring divider: floor(num * 2^(2*FB) / den), one quotient bit per stage.
`timescale 1ns / 1ps
module psd_div
	import psd_pkg::*;
#(
	parameter int CW = COORD_BITS_DEF,
	parameter int FB = FRAC_BITS_DEF
) (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       en,
	input  tag_t                       in_tag,
	input  logic [4*CW+1:0]            num,
	input  logic [2*CW:0]              den,
	output tag_t                       out_tag,
	output logic [2*CW+2*FB:0]         quo
);
	localparam int DVW = 2 * CW + 1;
	localparam int QW  = 2 * CW + 1 + 2 * FB;
	localparam int NW  = 4 * CW + 2;

	logic [QW:0]     vld_s;
	case_t           code_s [QW+1];
	logic [DVW-1:0]  rem_s  [QW+1];
	logic [DVW-1:0]  den_s  [QW+1];
	logic [QW-1:0]   low_s  [QW+1];
	logic [QW-1:0]   quo_s  [QW+1];

	// quotient is known to fit QW bits, so the top part starts below den
	assign vld_s[0]  = in_tag.valid;
	assign code_s[0] = in_tag.code;
	assign rem_s[0]  = num[NW-1:DVW];
	assign den_s[0]  = den;
	assign low_s[0]  = QW'(num[DVW-1:0]) << (2 * FB);
	assign quo_s[0]  = '0;

	for (genvar k = 0; k < QW; k++) begin : g_stage
		logic [DVW:0] trial, diff;
		logic         ge;

		always_comb begin
			trial = {rem_s[k], low_s[k][QW-1]};
			ge    = trial >= {1'b0, den_s[k]};
			diff  = trial - {1'b0, den_s[k]};
		end

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				vld_s[k+1] <= 1'b0;
			end else if (en) begin
				vld_s[k+1] <= vld_s[k];
			end
		end

		always_ff @(posedge clk) begin
			if (en) begin
				code_s[k+1] <= code_s[k];
				rem_s[k+1]  <= ge ? diff[DVW-1:0] : trial[DVW-1:0];
				den_s[k+1]  <= den_s[k];
				low_s[k+1]  <= low_s[k] << 1;
				quo_s[k+1]  <= {quo_s[k][QW-2:0], ge};
			end
		end
	end

	assign out_tag.valid = vld_s[QW];
	assign out_tag.code  = code_s[QW];
	assign quo           = quo_s[QW];

endmodule

FILE: rtl/psd_sqrt.sv
// Pipelined integer square root, one root bit per stage.
`timescale 1ns / 1ps
module psd_sqrt
	import psd_pkg::*;
#(
	parameter int CW = COORD_BITS_DEF,
	parameter int FB = FRAC_BITS_DEF
) (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  logic                                 en,
	input  tag_t                                 in_tag,
	input  logic [2*CW+2*FB:0]                   rad,
	output tag_t                                 out_tag,
	output logic [(2*CW+2*FB+2)/2-1:0]           root
);
	localparam int QW = 2 * CW + 1 + 2 * FB;
	localparam int RW = (QW + 1) / 2;
	localparam int MW = RW + 2;

	logic [RW:0]       vld_s;
	case_t             code_s [RW+1];
	logic [MW-1:0]     rem_s  [RW+1];
	logic [RW-1:0]     root_s [RW+1];
	logic [2*RW-1:0]   rad_s  [RW+1];

	assign vld_s[0]  = in_tag.valid;
	assign code_s[0] = in_tag.code;
	assign rem_s[0]  = '0;
	assign root_s[0] = '0;
	assign rad_s[0]  = (2*RW)'(rad);

	for (genvar k = 0; k < RW; k++) begin : g_stage
		logic [MW+1:0] cur, trial, diff;
		logic          ge;

		always_comb begin
			cur   = {rem_s[k], rad_s[k][2*RW-1:2*RW-2]};
			trial = (MW+2)'({root_s[k], 2'b01});
			ge    = cur >= trial;
			diff  = cur - trial;
		end

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				vld_s[k+1] <= 1'b0;
			end else if (en) begin
				vld_s[k+1] <= vld_s[k];
			end
		end

		always_ff @(posedge clk) begin
			if (en) begin
				code_s[k+1] <= code_s[k];
				rem_s[k+1]  <= ge ? diff[MW-1:0] : cur[MW-1:0];
				root_s[k+1] <= {root_s[k][RW-2:0], ge};
				rad_s[k+1]  <= rad_s[k] << 2;
			end
		end
	end

	assign out_tag.valid = vld_s[RW];
	assign out_tag.code  = code_s[RW];
	assign root          = root_s[RW];

endmodule

FILE: rtl/point_segment_distance.sv
// Top level of the point-to-segment distance pipeline.
`timescale 1ns / 1ps
// Point-to-segment distance. Each query transaction carries a point P and the
// endpoints A and B of a segment; the block returns floor(dist * 2^FRAC_BITS),
// saturated to 25 bits, and a case code (degenerate, nearest A, nearest B,
// interior). One transaction is accepted every clock cycle while no stall
// holds the pipeline. The stages are six front-end stages (differences,
// products, dot/cross sums, case select, squaring, operand select), one
// divider stage per quotient bit, one square-root stage per root bit and the
// output register. Endpoint cases run through the same divider with a divisor
// of one. The whole pipeline advances together; it halts only while a result
// sits in the output register and the sink is not ready, and then query.ready
// is low.
module point_segment_distance
	import psd_pkg::*;
#(
	parameter int COORD_BITS = COORD_BITS_DEF,
	parameter int FRAC_BITS  = FRAC_BITS_DEF
) (
	input  logic          clk,
	input  logic          arst_n,
	psd_query_if.sink     query,
	psd_result_if.source  result
);
	localparam int QW = 2 * COORD_BITS + 1 + 2 * FRAC_BITS;
	localparam int RW = (QW + 1) / 2;

	logic en;

	// front end -> divider
	tag_t                    front_tag;
	logic [4*COORD_BITS+1:0] front_num;
	logic [2*COORD_BITS:0]   front_den;

	// divider -> square root
	tag_t            div_tag;
	logic [QW-1:0]   div_quo;

	// square root -> output register
	tag_t            sq_tag;
	logic [RW-1:0]   sq_root;

	// output register
	logic                 out_valid_q;
	logic [DIST_W-1:0]    dist_q;
	case_t                code_q;

	// stall: everything moves unless a held result is not being taken
	assign en          = !out_valid_q || result.ready;
	assign query.ready = en;

	psd_front #(
		.CW (COORD_BITS)
	) u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.en       (en),
		.in_valid (query.valid),
		.px       (query.point_x),
		.py       (query.point_y),
		.ax       (query.seg_start_x),
		.ay       (query.seg_start_y),
		.bx       (query.seg_end_x),
		.by       (query.seg_end_y),
		.tag      (front_tag),
		.num      (front_num),
		.den      (front_den)
	);

	psd_div #(
		.CW (COORD_BITS),
		.FB (FRAC_BITS)
	) u_div (
		.clk     (clk),
		.arst_n  (arst_n),
		.en      (en),
		.in_tag  (front_tag),
		.num     (front_num),
		.den     (front_den),
		.out_tag (div_tag),
		.quo     (div_quo)
	);

	psd_sqrt #(
		.CW (COORD_BITS),
		.FB (FRAC_BITS)
	) u_sqrt (
		.clk     (clk),
		.arst_n  (arst_n),
		.en      (en),
		.in_tag  (div_tag),
		.rad     (div_quo),
		.out_tag (sq_tag),
		.root    (sq_root)
	);

	// saturate the root into the 25-bit result field
	logic [RW+DIST_W-1:0] root_w;
	logic [DIST_W-1:0]    dist_sat;

	assign root_w   = (RW + DIST_W)'(sq_root);
	assign dist_sat = (root_w > (RW + DIST_W)'(DIST_MAX)) ? DIST_MAX : root_w[DIST_W-1:0];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (en) begin
			out_valid_q <= sq_tag.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			dist_q <= dist_sat;
			code_q <= sq_tag.code;
		end
	end

	assign result.valid        = out_valid_q;
	assign result.distance_q8  = dist_q;
	assign result.nearest_case = code_q;

`ifndef SYNTHESIS
	// endpoint cases must reach the divider with a unit divisor
	a_unit_den: assert property (@(posedge clk) disable iff (!arst_n)
		front_tag.valid && front_tag.code != CASE_INTERIOR |-> front_den == 1)
		else $error("endpoint case with non-unit divisor");

	// the divider never sees a zero divisor
	a_den_nonzero: assert property (@(posedge clk) disable iff (!arst_n)
		front_tag.valid |-> front_den != 0)
		else $error("zero divisor entered the divider");

	// a stall freezes the tail of the pipeline
	a_stall_hold: assert property (@(posedge clk) disable iff (!arst_n)
		!en |=> $stable(sq_root) && $stable(sq_tag))
		else $error("pipeline moved during a stall");
`endif

endmodule
